### hw/rtl/twqs_pkg.sv
`default_nettype none
package twqs_pkg;

    typedef enum logic [2:0] {
        CMD_SLEEP     = 3'd0,
        CMD_WAIT      = 3'd1,
        CMD_SIGNAL    = 3'd2,
        CMD_BROADCAST = 3'd3,
        CMD_TICK      = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_TIMEOUT  = 2'd1,
        CAUSE_SIGNALED = 2'd2
    } t_cause;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_ORD,
        S_ENQ_INFO,
        S_ENQ_CMP,
        S_SCAN_ORD,
        S_SCAN_INFO,
        S_SCAN_EVAL,
        S_PEND_RD,
        S_PEND_EMIT,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/twqs_ram.sv
`default_nettype none
module twqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/timed_wait_queue_scheduler.sv
// Sleep/wait compares entries from the tail toward the head, stopping at the insertion
// point; an ignored or unused command goes straight to its result; signal/broadcast walk
// every waiting entry; tick walks every waiting entry, then every pending one. One command
// at a time; each entry's order RAM read addresses the task info RAM, both registered reads.
// Results are registered, each a one-cycle strobe, and cannot be stalled.
// Reset (synchronous, active low) clears counts and task valid bits.
`default_nettype none
module timed_wait_queue_scheduler
    import twqs_pkg::*;
#(
    parameter int TASKS     = 16,
    parameter int SIGNALS   = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [3:0]  i_task_id,
    input  wire logic [3:0]  i_signal_id,
    input  wire logic [31:0] i_duration,
    input  wire logic [31:0] i_now,
    output logic             o_result_valid,
    output logic [3:0]       o_woken_task,
    output logic             o_woken,
    output logic [1:0]       o_cause,
    output logic [4:0]       o_matched,
    output logic             o_status,
    output logic             o_last
);

    localparam int AW     = $clog2(TASKS);
    localparam int CW     = $clog2(TASKS + 1);
    localparam int INFO_W = TIME_BITS + 6;

    // info word: {expiry, has_signal, signal, pending}
    t_state              r_state, n_state;
    logic [2:0]          r_cmd, n_cmd;
    logic [AW-1:0]       r_task, n_task;
    logic [3:0]          r_sig, n_sig;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_exp, n_exp;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_wr, n_wr;
    logic [AW-1:0]       r_cur, n_cur;
    logic [CW-1:0]       r_wcount, n_wcount;
    logic [CW-1:0]       r_pcount, n_pcount;
    logic [4:0]          r_matched, n_matched;
    logic                r_status, n_status;
    logic                r_active, n_active;
    logic [TASKS-1:0]    r_valid, n_valid;
    logic                r_hold_v, n_hold_v;
    logic [3:0]          r_hold_task, n_hold_task;
    logic [1:0]          r_hold_cause, n_hold_cause;

    logic                r_ov, n_ov;
    logic [3:0]          r_otask, n_otask;
    logic                r_owoken, n_owoken;
    logic [1:0]          r_ocause, n_ocause;
    logic [4:0]          r_omatched, n_omatched;
    logic                r_ostatus, n_ostatus;
    logic                r_olast, n_olast;

    logic                ord_we, info_we, pend_we;
    logic [AW-1:0]       ord_waddr, ord_raddr, info_waddr, info_raddr, pend_waddr, pend_raddr;
    logic [AW-1:0]       ord_wdata, ord_rdata, pend_wdata, pend_rdata;
    logic [INFO_W-1:0]   info_wdata, info_rdata;

    logic [TIME_BITS-1:0] dur_t, now_t, info_exp;
    logic                info_has;
    logic [3:0]          info_sig;
    logic [CW-1:0]       idx_m1;
    logic                task_ok, sig_ok, hit;
    logic [AW-1:0]       in_task;

    assign dur_t    = TIME_BITS'(i_duration);
    assign now_t    = TIME_BITS'(i_now);
    assign in_task  = AW'(i_task_id);
    assign task_ok  = (32'(i_task_id) < TASKS) && !r_valid[in_task];
    assign sig_ok   = 32'(i_signal_id) < SIGNALS;
    assign info_exp = info_rdata[INFO_W-1:6];
    assign info_has = info_rdata[5];
    assign info_sig = info_rdata[4:1];
    assign idx_m1   = r_idx - 1'b1;

    twqs_ram #(.WIDTH(AW), .DEPTH(TASKS)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    twqs_ram #(.WIDTH(INFO_W), .DEPTH(TASKS)) u_info (
        .i_clk(i_clk), .i_we(info_we), .i_waddr(info_waddr), .i_wdata(info_wdata),
        .i_raddr(info_raddr), .o_rdata(info_rdata)
    );

    // pending list stored reversed: head is the highest filled slot
    twqs_ram #(.WIDTH(AW), .DEPTH(TASKS)) u_pend (
        .i_clk(i_clk), .i_we(pend_we), .i_waddr(pend_waddr), .i_wdata(pend_wdata),
        .i_raddr(pend_raddr), .o_rdata(pend_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wcount  <= '0;
            r_pcount  <= '0;
            r_valid   <= '0;
            r_hold_v  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wcount  <= n_wcount;
            r_pcount  <= n_pcount;
            r_valid   <= n_valid;
            r_hold_v  <= n_hold_v;
            r_ov      <= n_ov;
        end
        r_cmd        <= n_cmd;
        r_task       <= n_task;
        r_sig        <= n_sig;
        r_now        <= n_now;
        r_exp        <= n_exp;
        r_idx        <= n_idx;
        r_wr         <= n_wr;
        r_cur        <= n_cur;
        r_matched    <= n_matched;
        r_status     <= n_status;
        r_active     <= n_active;
        r_hold_task  <= n_hold_task;
        r_hold_cause <= n_hold_cause;
        r_otask      <= n_otask;
        r_owoken     <= n_owoken;
        r_ocause     <= n_ocause;
        r_omatched   <= n_omatched;
        r_ostatus    <= n_ostatus;
        r_olast      <= n_olast;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_task       = r_task;
        n_sig        = r_sig;
        n_now        = r_now;
        n_exp        = r_exp;
        n_idx        = r_idx;
        n_wr         = r_wr;
        n_cur        = r_cur;
        n_wcount     = r_wcount;
        n_pcount     = r_pcount;
        n_matched    = r_matched;
        n_status     = r_status;
        n_active     = r_active;
        n_valid      = r_valid;
        n_hold_v     = r_hold_v;
        n_hold_task  = r_hold_task;
        n_hold_cause = r_hold_cause;
        n_ov         = 1'b0;
        n_otask      = r_hold_task;
        n_owoken     = 1'b1;
        n_ocause     = r_hold_cause;
        n_omatched   = '0;
        n_ostatus    = STATUS_OK;
        n_olast      = 1'b0;
        ord_we       = 1'b0;
        ord_waddr    = r_wr[AW-1:0];
        ord_wdata    = r_cur;
        ord_raddr    = r_idx[AW-1:0];
        info_we      = 1'b0;
        info_waddr   = r_cur;
        info_wdata   = {info_exp, 1'b0, 4'd0, 1'b1};
        info_raddr   = ord_rdata;
        pend_we      = 1'b0;
        pend_waddr   = r_pcount[AW-1:0];
        pend_wdata   = r_cur;
        pend_raddr   = idx_m1[AW-1:0];
        hit          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_task    = in_task;
                    n_sig     = i_signal_id;
                    n_now     = now_t;
                    n_exp     = (&dur_t) ? '1 : dur_t + now_t;
                    n_matched = '0;
                    n_status  = STATUS_OK;
                    n_wr      = '0;
                    n_idx     = '0;
                    case (i_cmd)
                        CMD_SLEEP, CMD_WAIT: begin
                            n_idx = r_wcount;
                            if (task_ok && (i_cmd == CMD_SLEEP || sig_ok)) begin
                                n_state = S_ENQ_ORD;
                            end else begin
                                n_status = STATUS_IGNORED;
                                n_state  = S_FINISH;
                            end
                        end
                        CMD_SIGNAL, CMD_BROADCAST: begin
                            n_active = sig_ok;
                            n_state  = S_SCAN_ORD;
                        end
                        CMD_TICK: begin
                            n_active = 1'b1;
                            n_state  = S_SCAN_ORD;
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end

            // insertion walks from the tail, shifting entries up one slot
            S_ENQ_ORD: begin
                ord_raddr = idx_m1[AW-1:0];
                if (r_idx == '0) begin
                    hit     = 1'b1;
                end else begin
                    n_state = S_ENQ_INFO;
                end
            end
            S_ENQ_INFO: begin
                n_cur   = ord_rdata;
                n_state = S_ENQ_CMP;
            end
            S_ENQ_CMP: begin
                if (info_exp < r_exp) begin
                    hit = 1'b1;
                end else begin
                    ord_we    = 1'b1;
                    ord_waddr = r_idx[AW-1:0];
                    ord_wdata = r_cur;
                    n_idx     = idx_m1;
                    n_state   = S_ENQ_ORD;
                end
            end

            // forward walk with compaction: removed entries are skipped
            S_SCAN_ORD: begin
                if (r_idx == r_wcount) begin
                    n_wcount = r_wr;
                    if (r_cmd == CMD_TICK) begin
                        n_idx   = r_pcount;
                        n_state = S_PEND_RD;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_SCAN_INFO;
                end
            end
            S_SCAN_INFO: begin
                n_cur   = ord_rdata;
                n_state = S_SCAN_EVAL;
            end
            S_SCAN_EVAL: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_SCAN_ORD;
                if (r_cmd == CMD_TICK) begin
                    if (r_active && r_now >= info_exp) begin
                        n_valid[r_cur] = 1'b0;
                        n_ov         = r_hold_v;
                        n_hold_v     = 1'b1;
                        n_hold_task  = 4'(r_cur);
                        n_hold_cause = CAUSE_TIMEOUT;
                    end else begin
                        n_active = 1'b0;
                        ord_we   = 1'b1;
                        n_wr     = r_wr + 1'b1;
                    end
                end else if (r_active && info_has && info_sig == r_sig) begin
                    info_we   = 1'b1;
                    pend_we   = 1'b1;
                    n_pcount  = r_pcount + 1'b1;
                    n_matched = r_matched + 1'b1;
                    if (r_cmd == CMD_SIGNAL) begin
                        n_active = 1'b0;
                    end
                end else begin
                    ord_we = 1'b1;
                    n_wr   = r_wr + 1'b1;
                end
            end

            S_PEND_RD: begin
                if (r_idx == '0) begin
                    n_pcount = '0;
                    n_state  = S_FINISH;
                end else begin
                    n_state  = S_PEND_EMIT;
                end
            end
            S_PEND_EMIT: begin
                n_valid[pend_rdata] = 1'b0;
                n_ov         = r_hold_v;
                n_hold_v     = 1'b1;
                n_hold_task  = 4'(pend_rdata);
                n_hold_cause = CAUSE_SIGNALED;
                n_idx        = idx_m1;
                n_state      = S_PEND_RD;
            end

            S_FINISH: begin
                n_ov     = 1'b1;
                n_olast  = 1'b1;
                n_hold_v = 1'b0;
                if (!r_hold_v) begin
                    n_otask    = '0;
                    n_owoken   = 1'b0;
                    n_ocause   = CAUSE_NONE;
                    n_omatched = r_matched;
                    n_ostatus  = r_status;
                end
                n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        // insertion point found: place the task and record its info
        if (hit) begin
            ord_we         = 1'b1;
            ord_waddr      = r_idx[AW-1:0];
            ord_wdata      = r_task;
            info_we        = 1'b1;
            info_waddr     = r_task;
            info_wdata     = {r_exp, r_cmd == CMD_WAIT, r_sig, 1'b0};
            n_valid[r_task] = 1'b1;
            n_wcount       = r_wcount + 1'b1;
            n_state        = S_FINISH;
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_result_valid = r_ov;
    assign o_woken_task   = r_otask;
    assign o_woken        = r_owoken;
    assign o_cause        = r_ocause;
    assign o_matched      = r_omatched;
    assign o_status       = r_ostatus;
    assign o_last         = r_olast;

endmodule
`default_nettype wire

### hw/rtl/twqs_checker.sv
`default_nettype none
module twqs_checker
    import twqs_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_result_valid,
    input wire logic [3:0] o_woken_task,
    input wire logic       o_woken,
    input wire logic [1:0] o_cause,
    input wire logic       o_last
);

    // an accepted command raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // the final result appears as the block returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |-> !busy)
        else $error("final result while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> busy)
        else $error("non-final result after command ended");

    // only woken results may be followed by more results
    a_unwoken_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_woken |-> o_last && o_cause == CAUSE_NONE
            && o_woken_task == 4'd0)
        else $error("empty result not final or carries a task");

endmodule

bind timed_wait_queue_scheduler twqs_checker u_twqs_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_result_valid(o_result_valid),
    .o_woken_task(o_woken_task),
    .o_woken(o_woken),
    .o_cause(o_cause),
    .o_last(o_last)
);
`default_nettype wire

### tb/sv/tb_timed_wait_queue_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_timed_wait_queue_scheduler;
    import twqs_pkg::*;

    localparam int NTASK = 16;
    localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;
    localparam logic [1:0] AT_READY = 2'd0;
    localparam logic [1:0] AT_WAITING = 2'd1;
    localparam logic [1:0] AT_PENDING = 2'd2;
    localparam logic [4:0] NO_SIG = 5'h1F;

    typedef struct packed {
        logic [3:0] woken_task;
        logic       woken;
        logic [1:0] cause;
        logic [4:0] matched;
        logic       status;
        logic       last;
    } wake_rec_t;

    class wake_scoreboard;
        logic [3:0]  wq [$];
        logic [3:0]  pq [$];
        logic [31:0] expiry [NTASK];
        logic [4:0]  wsig [NTASK];
        logic [1:0]  place [NTASK];
        wake_rec_t   pending_wakes [$];
        int          errors;

        function new();
            errors = 0;
            for (int i = 0; i < NTASK; i++) begin
                expiry[i] = '0;
                wsig[i] = NO_SIG;
                place[i] = AT_READY;
            end
        endfunction

        function wake_rec_t mk(logic [3:0] t, logic w, logic [1:0] c,
                               logic [4:0] m, logic s, logic l);
            wake_rec_t r;
            r.woken_task = t; r.woken = w; r.cause = c;
            r.matched = m; r.status = s; r.last = l;
            return r;
        endfunction

        function logic insert_waiter(logic [3:0] t, logic [4:0] sg, logic [31:0] dur,
                                     logic [31:0] now);
            logic [31:0] e;
            int pos;
            if (place[t] != AT_READY || wq.size() >= NTASK) return STATUS_IGNORED;
            e = (dur == FOREVER) ? FOREVER : now + dur;
            pos = 0;
            while (pos < wq.size() && expiry[wq[pos]] < e) pos++;
            wq.insert(pos, t);
            expiry[t] = e;
            wsig[t] = sg;
            place[t] = AT_WAITING;
            return STATUS_OK;
        endfunction

        function logic [4:0] raise(logic [3:0] sg, bit all);
            logic [4:0] moved;
            int pos;
            logic [3:0] t;
            moved = 0;
            pos = 0;
            while (pos < wq.size()) begin
                t = wq[pos];
                if (wsig[t] == {1'b0, sg}) begin
                    wq.delete(pos);
                    wsig[t] = NO_SIG;
                    place[t] = AT_PENDING;
                    pq.push_front(t);
                    moved++;
                    if (!all) break;
                end else pos++;
            end
            return moved;
        endfunction

        function void note_command(logic [2:0] cmd, logic [3:0] tid, logic [3:0] sg,
                                   logic [31:0] dur, logic [31:0] now);
            int n;
            logic [3:0] t;
            case (cmd)
                CMD_SLEEP: pending_wakes.push_back(mk(0, 0, CAUSE_NONE, 0,
                    insert_waiter(tid, NO_SIG, dur, now), 1));
                CMD_WAIT: pending_wakes.push_back(mk(0, 0, CAUSE_NONE, 0,
                    insert_waiter(tid, {1'b0, sg}, dur, now), 1));
                CMD_SIGNAL: pending_wakes.push_back(mk(0, 0, CAUSE_NONE,
                    raise(sg, 0), STATUS_OK, 1));
                CMD_BROADCAST: pending_wakes.push_back(mk(0, 0, CAUSE_NONE,
                    raise(sg, 1), STATUS_OK, 1));
                CMD_TICK: begin
                    n = 0;
                    while (wq.size() > 0 && now >= expiry[wq[0]]) begin
                        t = wq.pop_front();
                        wsig[t] = NO_SIG;
                        place[t] = AT_READY;
                        pending_wakes.push_back(mk(t, 1, CAUSE_TIMEOUT, 0, STATUS_OK, 0));
                        n++;
                    end
                    foreach (pq[i]) begin
                        place[pq[i]] = AT_READY;
                        pending_wakes.push_back(mk(pq[i], 1, CAUSE_SIGNALED, 0,
                            STATUS_OK, 0));
                        n++;
                    end
                    pq.delete();
                    if (n == 0) pending_wakes.push_back(mk(0, 0, CAUSE_NONE, 0, STATUS_OK, 1));
                    else pending_wakes[pending_wakes.size() - 1].last = 1;
                end
                default: pending_wakes.push_back(mk(0, 0, CAUSE_NONE, 0, STATUS_OK, 1));
            endcase
        endfunction

        function void check_result(wake_rec_t got);
            wake_rec_t exp;
            if (pending_wakes.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending_wakes.pop_front();
            if (exp !== got) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, start = 0;
    logic [2:0] i_cmd = 0;
    logic [3:0] i_task_id = 0, i_signal_id = 0;
    logic [31:0] i_duration = 0, i_now = 0;
    wire busy, o_result_valid, o_woken, o_status, o_last;
    wire [3:0] o_woken_task;
    wire [1:0] o_cause;
    wire [4:0] o_matched;

    wake_scoreboard sb;
    int send_idle_pct;
    logic [31:0] clk_ms;

    always #6 i_clk = ~i_clk;

    timed_wait_queue_scheduler dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_command(i_cmd, i_task_id, i_signal_id, i_duration, i_now);
        if (i_rst_n && o_result_valid)
            sb.check_result({o_woken_task, o_woken, o_cause, o_matched, o_status, o_last});
    end

    task automatic issue(logic [2:0] c, logic [3:0] t, logic [3:0] s,
                         logic [31:0] d, logic [31:0] n);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        start <= 1; i_cmd <= c; i_task_id <= t; i_signal_id <= s;
        i_duration <= d; i_now <= n;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start <= 0;
    endtask

    task automatic drain();
        while (sb.pending_wakes.size() > 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic random_item();
        int r;
        logic [31:0] d;
        r = $urandom_range(99);
        d = ($urandom_range(9) == 0) ? FOREVER :
            ($urandom_range(9) == 0) ? $urandom() : $urandom_range(40);
        clk_ms = clk_ms + $urandom_range(8);
        if (r < 30) issue(CMD_SLEEP, 4'($urandom), 4'($urandom), d, clk_ms);
        else if (r < 55) issue(CMD_WAIT, 4'($urandom), 4'($urandom_range(3)), d, clk_ms);
        else if (r < 65)
            issue(CMD_SIGNAL, 4'($urandom), 4'($urandom_range(3)), $urandom, clk_ms);
        else if (r < 72) issue(CMD_BROADCAST, 4'($urandom), 4'($urandom), $urandom, clk_ms);
        else if (r < 95) issue(CMD_TICK, 4'($urandom), 4'($urandom), $urandom, clk_ms);
        else issue(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), $urandom, $urandom);
    endtask

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        sb = new();
        send_idle_pct = 0;
        clk_ms = 100;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed
        issue(CMD_SLEEP, 0, 0, 0, 32'd0);
        issue(CMD_SLEEP, 0, 0, 5, 32'd0);            // already queued
        issue(CMD_SLEEP, 15, 15, FOREVER, 32'd0);
        issue(CMD_WAIT, 3, 15, 32'hFFFF_FFFE, 32'd7); // wraps
        issue(CMD_WAIT, 4, 2, 10, 32'd0);
        issue(CMD_WAIT, 5, 2, 10, 32'd0);
        issue(CMD_WAIT, 6, 2, 3, 32'd0);
        issue(CMD_SIGNAL, 0, 2, 0, 0);
        issue(CMD_WAIT, 6, 1, 1, 0);                 // pending, ignored
        issue(CMD_BROADCAST, 0, 2, 0, 0);
        issue(CMD_BROADCAST, 0, 9, 0, 0);
        issue(CMD_TICK, 0, 0, 0, 32'd4);
        issue(CMD_TICK, 0, 0, 0, 32'd4);             // empty
        issue(3'd5, 4'hF, 4'hF, FOREVER, FOREVER);
        issue(3'd7, 0, 0, 0, 0);
        issue(CMD_TICK, 0, 0, 0, FOREVER);           // forever expires
        for (int i = 0; i < NTASK; i++) issue(CMD_WAIT, 4'(i), 4'(i), 32'(i), 32'd50);
        issue(CMD_BROADCAST, 0, 4'd7, 0, 0);
        issue(CMD_TICK, 0, 0, 0, FOREVER);
        drain();
        send_idle_pct = 38;
        repeat (22) random_item();
        drain();                                      // sender waits for all results
        send_idle_pct = 84;
        repeat (22) random_item();
        send_idle_pct = 0;
        repeat (22) random_item();
        issue(CMD_TICK, 0, 0, 0, FOREVER);
        drain();
        if (sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### timed_wait_queue_scheduler.f
hw/rtl/twqs_pkg.sv
hw/rtl/twqs_ram.sv
hw/rtl/timed_wait_queue_scheduler.sv
hw/rtl/twqs_checker.sv
tb/sv/tb_timed_wait_queue_scheduler.sv
